// ===== rtl/c2e_pkg.sv =====
// shared types, constants and the month length table for the calendar to epoch converter
package c2e_pkg;

   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int EPOCH_W  = 33;
   localparam int ZONE_W   = 17;
   localparam int DAYS_W   = 16;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;

   // residues of the epoch year, used to seed the leap counters
   localparam logic [1:0] EPOCH_MOD4   = 2'd2;
   localparam logic [6:0] EPOCH_MOD100 = 7'd70;
   localparam logic [8:0] EPOCH_MOD400 = 9'd370;

   localparam logic [6:0] MOD100_LAST = 7'd99;
   localparam logic [8:0] MOD400_LAST = 9'd399;

   // for y < 4096, (y * 655) >> 16 is floor(y / 100) or one less
   localparam logic [9:0] RECIP100    = 10'd655;
   localparam int         RECIP_SHIFT = 16;

   localparam logic [EPOCH_W-1:0] SECS_PER_DAY  = 33'd86400;
   localparam logic [11:0]        SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]         SECS_PER_MIN  = 6'd60;

   localparam logic [8:0] DAYS_COMMON = 9'd365;
   localparam logic [8:0] DAYS_LEAP   = 9'd366;

   localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
   localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
   localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
   localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
   localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

   localparam logic csr_addr_zone = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAP_Q,
      ST_LEAP_R,
      ST_MONTHS,
      ST_YEARS,
      ST_SCALE,
      ST_SUM
   } c2e_state_type;

   typedef struct packed {
      logic in_ready;
      logic load;
      logic leap_q;
      logic leap_r;
      logic month_step;
      logic year_step;
      logic scale;
      logic sum_load;
   } c2e_cmd_type;

   typedef struct packed {
      logic in_valid;
      logic month_done;
      logic year_done;
      logic out_free;
   } c2e_stat_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
         MON_FEB: len = leap ? 5'd29 : 5'd28;
         default: len = 5'd30;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/c2e_if.sv =====
// valid/ready channel interfaces for calendar requests and epoch responses
interface c2e_req_if;
   import c2e_pkg::*;

   logic                valid;
   logic                ready;
   logic [YEAR_W-1:0]   year;
   logic [MONTH_W-1:0]  month;
   logic [DAY_W-1:0]    day;
   logic [HOUR_W-1:0]   hour;
   logic [MINUTE_W-1:0] minute;
   logic [SECOND_W-1:0] second;

   modport source (output valid, year, month, day, hour, minute, second, input ready);
   modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface c2e_rsp_if;
   import c2e_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [EPOCH_W-1:0] epoch_seconds;

   modport source (output valid, epoch_seconds, input ready);
   modport sink   (input valid, epoch_seconds, output ready);
endinterface

// ===== rtl/calendar_to_epoch_seconds_core.sv =====
// top level: calendar date and time to epoch seconds with zone offset register
// a request is captured, then passes the leap quotient and leap remainder states, the month
// loop, the year loop (year clamped to LAST_YEAR), the scale state and the sum state, which
// waits while the previous response is still held; a new request is taken only in idle, once
// the accumulation loop, adding one month or one year to the day count per cycle, is done
// reset: synchronous, clears the sequencer, the response valid and the zone offset to 0
module calendar_to_epoch_seconds_core #(
   parameter int LAST_YEAR = 2099
) (
   input  logic        clock,
   input  logic        reset,
   c2e_req_if.sink     req_ch,
   c2e_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import c2e_pkg::*;

   logic signed [ZONE_W-1:0] zone_ff;
   logic                     csr_wr;
   c2e_cmd_type              cmd;
   c2e_stat_type             stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= '0;
      end else if (csr_wr && (csr_paddr[2] == csr_addr_zone)) begin
         zone_ff <= csr_pwdata[ZONE_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == csr_addr_zone)
                     ? {{(32-ZONE_W){zone_ff[ZONE_W-1]}}, zone_ff} : 32'd0;

   c2e_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   c2e_dp #(
      .LAST_YEAR (LAST_YEAR)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .zone  (zone_ff),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

// ===== rtl/c2e_ctrl.sv =====
// sequencer for the leap test, month and year accumulation and final sum
module c2e_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  c2e_pkg::c2e_stat_type stat,
   output c2e_pkg::c2e_cmd_type  cmd
);
   import c2e_pkg::*;

   c2e_state_type state_ff;
   c2e_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            if (stat.in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LEAP_Q;
            end
         end
         ST_LEAP_Q: begin
            cmd.leap_q = 1'b1;
            state_in   = ST_LEAP_R;
         end
         ST_LEAP_R: begin
            cmd.leap_r = 1'b1;
            state_in   = ST_MONTHS;
         end
         ST_MONTHS: begin
            if (stat.month_done) begin
               state_in = ST_YEARS;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         ST_YEARS: begin
            if (stat.year_done) begin
               state_in = ST_SCALE;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            // hold here while the previous response is still waiting
            if (stat.out_free) begin
               cmd.sum_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/c2e_dp.sv =====
// datapath: field capture, leap test, day accumulator, scaling and output register
module c2e_dp #(
   parameter int LAST_YEAR = 2099
) (
   input  logic                                  clock,
   input  logic                                  reset,
   c2e_req_if.sink                               req,
   c2e_rsp_if.source                             rsp,
   input  logic signed [c2e_pkg::ZONE_W-1:0]     zone,
   input  c2e_pkg::c2e_cmd_type                  cmd,
   output c2e_pkg::c2e_stat_type                 stat
);
   import c2e_pkg::*;

   localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(LAST_YEAR);

   logic [YEAR_W-1:0]   year_ff;
   logic [MONTH_W-1:0]  month_ff;
   logic [DAY_W-1:0]    day_ff;
   logic [HOUR_W-1:0]   hour_ff;
   logic [MINUTE_W-1:0] minute_ff;
   logic [SECOND_W-1:0] second_ff;

   logic [5:0]          q_ff;
   logic                leap_ff;
   logic [MONTH_W-1:0]  mon_ctr_ff;
   logic [YEAR_W-1:0]   yr_ctr_ff;
   logic [1:0]          r4_ff;
   logic [6:0]          r100_ff;
   logic [8:0]          r400_ff;
   logic [DAYS_W-1:0]   days_ff;
   logic [EPOCH_W-1:0]  day_secs_ff;
   logic [16:0]         tod_ff;
   logic [EPOCH_W-1:0]  epoch_ff;
   logic                rsp_valid_ff;

   logic [YEAR_W-1:0]   year_sat;
   logic [21:0]         q_prod;
   logic [YEAR_W-1:0]   r_raw;
   logic                q_corr;
   logic [YEAR_W-1:0]   r_fix;
   logic [5:0]          q_fix;
   logic                leap_in;
   logic                leap_y;
   logic [ZONE_W-1:0]   day_count;
   logic [EPOCH_W-1:0]  day_secs_in;
   logic [16:0]         tod_in;
   logic [EPOCH_W-1:0]  epoch_in;

   assign year_sat = (req.year > YEAR_MAX) ? YEAR_MAX : req.year;

   // leap test of the captured year via reciprocal divide by 100
   assign q_prod  = 22'(year_ff) * 22'(RECIP100);
   assign r_raw   = year_ff - YEAR_W'(12'(q_ff) * 12'd100);
   assign q_corr  = (r_raw >= 12'd100);
   assign r_fix   = q_corr ? (r_raw - 12'd100) : r_raw;
   assign q_fix   = q_ff + 6'(q_corr);
   assign leap_in = (year_ff[1:0] == 2'd0) && ((r_fix != '0) || (q_fix[1:0] == 2'd0));

   assign leap_y = (r4_ff == 2'd0) && ((r100_ff != 7'd0) || (r400_ff == 9'd0));

   // day - 1 may go to minus one, so work in two's complement
   assign day_count   = ZONE_W'(days_ff) + ZONE_W'(day_ff) - ZONE_W'(1);
   assign day_secs_in = EPOCH_W'({{(EPOCH_W-ZONE_W){day_count[ZONE_W-1]}}, day_count}
                                 * SECS_PER_DAY);
   assign tod_in      = 17'(17'(hour_ff) * 17'(SECS_PER_HOUR))
                      + 17'(17'(minute_ff) * 17'(SECS_PER_MIN))
                      + 17'(second_ff);
   assign epoch_in    = day_secs_ff + EPOCH_W'(tod_ff)
                      - EPOCH_W'({{(EPOCH_W-ZONE_W){zone[ZONE_W-1]}}, zone});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         year_ff    <= year_sat;
         month_ff   <= req.month;
         day_ff     <= req.day;
         hour_ff    <= req.hour;
         minute_ff  <= req.minute;
         second_ff  <= req.second;
         mon_ctr_ff <= MON_JAN;
         yr_ctr_ff  <= EPOCH_YEAR;
         r4_ff      <= EPOCH_MOD4;
         r100_ff    <= EPOCH_MOD100;
         r400_ff    <= EPOCH_MOD400;
         days_ff    <= '0;
      end
      if (cmd.leap_q) begin
         q_ff <= q_prod[RECIP_SHIFT +: 6];
      end
      if (cmd.leap_r) begin
         leap_ff <= leap_in;
      end
      if (cmd.month_step) begin
         days_ff    <= days_ff + DAYS_W'(month_len(mon_ctr_ff, leap_ff));
         mon_ctr_ff <= mon_ctr_ff + MONTH_W'(1);
      end
      if (cmd.year_step) begin
         days_ff   <= days_ff + DAYS_W'(leap_y ? DAYS_LEAP : DAYS_COMMON);
         yr_ctr_ff <= yr_ctr_ff + YEAR_W'(1);
         r4_ff     <= r4_ff + 2'd1;
         r100_ff   <= (r100_ff == MOD100_LAST) ? 7'd0 : r100_ff + 7'd1;
         r400_ff   <= (r400_ff == MOD400_LAST) ? 9'd0 : r400_ff + 9'd1;
      end
      if (cmd.scale) begin
         day_secs_ff <= day_secs_in;
         tod_ff      <= tod_in;
      end
      if (cmd.sum_load) begin
         epoch_ff <= epoch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.sum_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign req.ready         = cmd.in_ready;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.epoch_seconds = epoch_ff;

   assign stat.in_valid   = req.valid;
   assign stat.month_done = (mon_ctr_ff >= month_ff);
   assign stat.year_done  = (yr_ctr_ff >= year_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp.ready;

   // a new result never overwrites one that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.sum_load |-> (!rsp_valid_ff || rsp.ready))
      else $error("response overwritten before transaction completed");

   a_month_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.month_step |-> (mon_ctr_ff < month_ff))
      else $error("month step past requested month");

   a_year_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.year_step |-> (yr_ctr_ff < year_ff))
      else $error("year step past requested year");

   a_days_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (days_ff == '0 && yr_ctr_ff == EPOCH_YEAR))
      else $error("accumulator not cleared on load");

   a_year_saturated: assert property (@(posedge clock) disable iff (reset)
      cmd.leap_q |-> (year_ff <= YEAR_MAX))
      else $error("captured year above last supported year");

endmodule
